>>> rtl/core/mpe_pkg.sv
package mpe_pkg;

    localparam int FRAC_BITS   = 6;
    localparam int SCREEN_MAX  = 1024;
    localparam int SHADE_COUNT = 10;

    localparam int PIX_W   = 10;
    localparam int SPAN_W  = 10;
    localparam int LIMIT_W = 16;
    localparam int CAP_W   = 4;
    localparam int SCR_W   = 11;
    localparam int GLYPH_W = 8;
    localparam int MAP_W   = PIX_W + SPAN_W;
    localparam int COORD_W = 22;
    localparam int PROD_W  = 2 * COORD_W;
    localparam int DCNT_W  = $clog2(MAP_W + 1);
    localparam int REM_W   = SCR_W + 1;

    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;

    localparam logic [2:0] REG_X_SPAN       = 3'd0;
    localparam logic [2:0] REG_X_OFFSET     = 3'd1;
    localparam logic [2:0] REG_Y_SPAN       = 3'd2;
    localparam logic [2:0] REG_Y_OFFSET     = 3'd3;
    localparam logic [2:0] REG_ESCAPE_LIMIT = 3'd4;
    localparam logic [2:0] REG_ITER_CAP     = 3'd5;
    localparam logic [2:0] REG_SCREEN_COLS  = 3'd6;
    localparam logic [2:0] REG_SCREEN_ROWS  = 3'd7;

    typedef struct packed {
        logic [SPAN_W-1:0]  x_span;
        logic [SPAN_W-1:0]  x_offset;
        logic [SPAN_W-1:0]  y_span;
        logic [SPAN_W-1:0]  y_offset;
        logic [LIMIT_W-1:0] escape_limit;
        logic [CAP_W-1:0]   iteration_cap;
        logic [SCR_W-1:0]   screen_columns;
        logic [SCR_W-1:0]   screen_rows;
    } t_cfg;

    typedef struct packed {
        logic              go;
        logic [MAP_W-1:0]  dividend;
        logic [SCR_W-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [MAP_W-1:0]  quotient;
    } t_div_rsp;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MAPX,
        S_DIVX,
        S_WAITX,
        S_MAPY,
        S_DIVY,
        S_WAITY,
        S_SQX,
        S_SQY,
        S_XY,
        S_UPD
    } t_state;

    function automatic logic [GLYPH_W-1:0] shade_glyph(input logic [CAP_W-1:0] idx);
        logic [GLYPH_W-1:0] g;
        case (idx)
            4'd0:    g = 8'h2E; // '.'
            4'd1:    g = 8'h2C; // ','
            4'd2:    g = 8'h5F; // '_'
            4'd3:    g = 8'h2D; // '-'
            4'd4:    g = 8'h2A; // '*'
            4'd5:    g = 8'h21; // '!'
            4'd6:    g = 8'h24; // '$'
            4'd7:    g = 8'h26; // '&'
            4'd8:    g = 8'h30; // '0'
            default: g = 8'h20; // ' '
        endcase
        return g;
    endfunction

endpackage

>>> rtl/core/mpe_mul.sv
// Shared signed multiplier, product registered.
module mpe_mul (
    input  logic                                i_clk,
    input  logic signed [mpe_pkg::COORD_W-1:0]  i_a,
    input  logic signed [mpe_pkg::COORD_W-1:0]  i_b,
    output logic signed [mpe_pkg::PROD_W-1:0]   o_p
);

    logic signed [mpe_pkg::PROD_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

>>> rtl/core/mpe_div.sv
// Restoring divider, one quotient bit per cycle.
module mpe_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mpe_pkg::t_div_req   i_req,
    output mpe_pkg::t_div_rsp   o_rsp
);

    logic [mpe_pkg::REM_W-1:0]  r_rem;
    logic [mpe_pkg::MAP_W-1:0]  r_quo;
    logic [mpe_pkg::SCR_W-1:0]  r_div;
    logic [mpe_pkg::DCNT_W-1:0] r_cnt;
    logic                       r_busy;
    logic                       r_done;
    logic                       r_zero;

    logic [mpe_pkg::REM_W-1:0]  trial;
    logic                       fits;

    assign trial = {r_rem[mpe_pkg::REM_W-2:0], r_quo[mpe_pkg::MAP_W-1]};
    assign fits  = trial >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == mpe_pkg::DCNT_W'(1));
            if (i_req.go) begin
                r_busy <= 1'b1;
                r_cnt  <= mpe_pkg::DCNT_W'(mpe_pkg::MAP_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - mpe_pkg::DCNT_W'(1);
                if (r_cnt == mpe_pkg::DCNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.go) begin
            r_rem  <= '0;
            r_quo  <= i_req.dividend;
            r_div  <= i_req.divisor;
            r_zero <= (i_req.divisor == '0);
        end else if (r_busy) begin
            r_rem <= fits ? (trial - {1'b0, r_div}) : trial;
            r_quo <= {r_quo[mpe_pkg::MAP_W-2:0], fits};
        end
    end

    // a zero divisor yields a zero quotient
    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_zero ? '0 : r_quo;

endmodule

>>> rtl/core/mpe_seq.sv
// Pixel sequencer: coordinate mapping and the escape-time loop,
// driving one shared multiplier and one iterative divider.
module mpe_seq (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  mpe_pkg::t_cfg                  i_cfg,
    input  logic                           i_start,
    input  logic [mpe_pkg::PIX_W-1:0]      i_column,
    input  logic [mpe_pkg::PIX_W-1:0]      i_row,
    output logic                           o_busy,
    output logic                           o_strobe,
    output logic [mpe_pkg::CAP_W-1:0]      o_shade_index,
    output logic [mpe_pkg::GLYPH_W-1:0]    o_glyph
);

    localparam int CW = mpe_pkg::COORD_W;
    localparam int PW = mpe_pkg::PROD_W;

    mpe_pkg::t_state r_state, n_state;

    logic [mpe_pkg::PIX_W-1:0]   r_col, r_row;
    logic [mpe_pkg::CAP_W-1:0]   r_cap, n_cap;
    logic [mpe_pkg::CAP_W-1:0]   r_iter, n_iter;
    logic signed [CW-1:0]        r_x0, n_x0, r_y0, n_y0;
    logic signed [CW-1:0]        r_x, n_x, r_y, n_y;
    logic signed [PW-1:0]        r_xs, n_xs, r_ys, n_ys;
    logic                        r_esc, n_esc;
    logic                        r_strobe, n_strobe;
    logic [mpe_pkg::CAP_W-1:0]   r_shade, n_shade;

    logic signed [CW-1:0]        mul_a, mul_b;
    logic signed [PW-1:0]        mul_p;
    logic signed [PW-1:0]        p_sh;
    logic signed [PW-1:0]        mag;
    logic [mpe_pkg::SCR_W-1:0]   div_cols, div_rows;
    logic signed [CW-1:0]        q_coord;
    mpe_pkg::t_div_req           div_req;
    mpe_pkg::t_div_rsp           div_rsp;

    mpe_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    mpe_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign p_sh = mul_p >>> mpe_pkg::FRAC_BITS;
    assign mag  = r_xs + p_sh;
    assign q_coord = $signed({{(CW - mpe_pkg::MAP_W){1'b0}}, div_rsp.quotient});

    // saturate divisors above the screen limit
    assign div_cols = (i_cfg.screen_columns > mpe_pkg::SCR_W'(mpe_pkg::SCREEN_MAX))
                    ? mpe_pkg::SCR_W'(mpe_pkg::SCREEN_MAX) : i_cfg.screen_columns;
    assign div_rows = (i_cfg.screen_rows > mpe_pkg::SCR_W'(mpe_pkg::SCREEN_MAX))
                    ? mpe_pkg::SCR_W'(mpe_pkg::SCREEN_MAX) : i_cfg.screen_rows;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= mpe_pkg::S_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == mpe_pkg::S_IDLE && i_start) begin
            r_col <= i_column;
            r_row <= i_row;
        end
        r_cap   <= n_cap;
        r_iter  <= n_iter;
        r_x0    <= n_x0;
        r_y0    <= n_y0;
        r_x     <= n_x;
        r_y     <= n_y;
        r_xs    <= n_xs;
        r_ys    <= n_ys;
        r_esc   <= n_esc;
        r_shade <= n_shade;
    end

    always_comb begin
        n_state  = r_state;
        n_cap    = r_cap;
        n_iter   = r_iter;
        n_x0     = r_x0;
        n_y0     = r_y0;
        n_x      = r_x;
        n_y      = r_y;
        n_xs     = r_xs;
        n_ys     = r_ys;
        n_esc    = r_esc;
        n_shade  = r_shade;
        n_strobe = 1'b0;
        mul_a    = r_x;
        mul_b    = r_x;
        div_req.go       = 1'b0;
        div_req.dividend = mul_p[mpe_pkg::MAP_W-1:0];
        div_req.divisor  = div_cols;

        unique case (r_state)
            mpe_pkg::S_IDLE: begin
                if (i_start) begin
                    // clamp the cap to one .. table size
                    if (i_cfg.iteration_cap == '0) begin
                        n_cap = mpe_pkg::CAP_W'(1);
                    end else if (i_cfg.iteration_cap > mpe_pkg::CAP_W'(mpe_pkg::SHADE_COUNT)) begin
                        n_cap = mpe_pkg::CAP_W'(mpe_pkg::SHADE_COUNT);
                    end else begin
                        n_cap = i_cfg.iteration_cap;
                    end
                    n_state = mpe_pkg::S_MAPX;
                end
            end
            mpe_pkg::S_MAPX: begin
                mul_a   = $signed({{(CW - mpe_pkg::PIX_W){1'b0}}, r_col});
                mul_b   = $signed({{(CW - mpe_pkg::SPAN_W){1'b0}}, i_cfg.x_span});
                n_state = mpe_pkg::S_DIVX;
            end
            mpe_pkg::S_DIVX: begin
                div_req.go = 1'b1;
                n_state    = mpe_pkg::S_WAITX;
            end
            mpe_pkg::S_WAITX: begin
                if (div_rsp.done) begin
                    n_x0    = q_coord - $signed({{(CW - mpe_pkg::SPAN_W){1'b0}}, i_cfg.x_offset});
                    n_state = mpe_pkg::S_MAPY;
                end
            end
            mpe_pkg::S_MAPY: begin
                mul_a   = $signed({{(CW - mpe_pkg::PIX_W){1'b0}}, r_row});
                mul_b   = $signed({{(CW - mpe_pkg::SPAN_W){1'b0}}, i_cfg.y_span});
                n_state = mpe_pkg::S_DIVY;
            end
            mpe_pkg::S_DIVY: begin
                div_req.go      = 1'b1;
                div_req.divisor = div_rows;
                n_state         = mpe_pkg::S_WAITY;
            end
            mpe_pkg::S_WAITY: begin
                div_req.divisor = div_rows;
                if (div_rsp.done) begin
                    n_y0    = q_coord - $signed({{(CW - mpe_pkg::SPAN_W){1'b0}}, i_cfg.y_offset});
                    n_x     = '0;
                    n_y     = '0;
                    n_iter  = '0;
                    n_state = mpe_pkg::S_SQX;
                end
            end
            mpe_pkg::S_SQX: begin
                mul_a   = r_x;
                mul_b   = r_x;
                n_state = mpe_pkg::S_SQY;
            end
            mpe_pkg::S_SQY: begin
                n_xs    = p_sh;
                mul_a   = r_y;
                mul_b   = r_y;
                n_state = mpe_pkg::S_XY;
            end
            mpe_pkg::S_XY: begin
                n_ys    = p_sh;
                n_esc   = mag > $signed({{(PW - mpe_pkg::LIMIT_W){1'b0}}, i_cfg.escape_limit});
                mul_a   = r_x;
                mul_b   = r_y;
                n_state = mpe_pkg::S_UPD;
            end
            mpe_pkg::S_UPD: begin
                if (r_esc) begin
                    n_shade  = r_iter - mpe_pkg::CAP_W'(1);
                    n_strobe = 1'b1;
                    n_state  = mpe_pkg::S_IDLE;
                end else begin
                    n_x    = CW'(r_xs - r_ys + PW'(r_x0));
                    n_y    = CW'((p_sh <<< 1) + PW'(r_y0));
                    n_iter = r_iter + mpe_pkg::CAP_W'(1);
                    if (n_iter == r_cap) begin
                        n_shade  = r_iter;
                        n_strobe = 1'b1;
                        n_state  = mpe_pkg::S_IDLE;
                    end else begin
                        n_state = mpe_pkg::S_SQX;
                    end
                end
            end
            default: begin
                n_state = mpe_pkg::S_IDLE;
            end
        endcase
    end

    assign o_busy        = (r_state != mpe_pkg::S_IDLE);
    assign o_strobe      = r_strobe;
    assign o_shade_index = r_shade;
    assign o_glyph       = mpe_pkg::shade_glyph(r_shade);

endmodule

>>> rtl/core/mandelbrot_pixel_escape.sv
// Mandelbrot escape-time evaluator for one pixel at a time. Raise start with
// i_column/i_row while busy is low; the pixel is taken at that edge and busy
// stays high until the result shows. The result appears on o_shade_index and
// o_glyph for exactly one cycle with o_strobe high; there is no way to hold
// it, so the receiver must take it in that cycle. Busy stays high through
// the coordinate mapping (two 20-bit divisions, each a multiply state, a
// launch state and a wait on the bit-per-cycle divider) plus the states
// SQX, SQY, XY and UPD of each iteration through the single shared
// multiplier, at an iteration cap of ten at most. The strobe shows in the
// first cycle with busy low, and a new start is taken in that same cycle,
// so the next pixel can follow as soon as the last result shows.
// Registers sit on an APB port at byte addresses 4*i: x_span, x_offset,
// y_span, y_offset, escape_limit, iteration_cap, screen_columns, screen_rows;
// write them only while busy is low. A cap of zero acts as one, a cap above
// ten as ten; a screen size of zero maps every pixel to the offset edge, one
// above 1024 acts as 1024.
module mandelbrot_pixel_escape (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [mpe_pkg::ADDR_W-1:0]     paddr,
    input  logic [mpe_pkg::DATA_W-1:0]     pwdata,
    output logic [mpe_pkg::DATA_W-1:0]     prdata,
    output logic                           pready,
    // pixel command
    input  logic                           start,
    output logic                           busy,
    input  logic [mpe_pkg::PIX_W-1:0]      i_column,
    input  logic [mpe_pkg::PIX_W-1:0]      i_row,
    // result
    output logic                           o_strobe,
    output logic [mpe_pkg::CAP_W-1:0]      o_shade_index,
    output logic [mpe_pkg::GLYPH_W-1:0]    o_glyph
);

    mpe_pkg::t_cfg r_cfg;
    logic [2:0]    reg_idx;
    logic          wr_beat;

    assign pready  = 1'b1;
    assign reg_idx = paddr[mpe_pkg::ADDR_W-1:2];
    // a write beat completes in the access phase
    assign wr_beat = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.x_span         <= mpe_pkg::SPAN_W'(224);
            r_cfg.x_offset       <= mpe_pkg::SPAN_W'(160);
            r_cfg.y_span         <= mpe_pkg::SPAN_W'(128);
            r_cfg.y_offset       <= mpe_pkg::SPAN_W'(64);
            r_cfg.escape_limit   <= mpe_pkg::LIMIT_W'(512);
            r_cfg.iteration_cap  <= mpe_pkg::CAP_W'(10);
            r_cfg.screen_columns <= mpe_pkg::SCR_W'(80);
            r_cfg.screen_rows    <= mpe_pkg::SCR_W'(24);
        end else if (wr_beat) begin
            unique case (reg_idx)
                mpe_pkg::REG_X_SPAN:       r_cfg.x_span <= pwdata[mpe_pkg::SPAN_W-1:0];
                mpe_pkg::REG_X_OFFSET:     r_cfg.x_offset <= pwdata[mpe_pkg::SPAN_W-1:0];
                mpe_pkg::REG_Y_SPAN:       r_cfg.y_span <= pwdata[mpe_pkg::SPAN_W-1:0];
                mpe_pkg::REG_Y_OFFSET:     r_cfg.y_offset <= pwdata[mpe_pkg::SPAN_W-1:0];
                mpe_pkg::REG_ESCAPE_LIMIT: r_cfg.escape_limit <= pwdata[mpe_pkg::LIMIT_W-1:0];
                mpe_pkg::REG_ITER_CAP:     r_cfg.iteration_cap <= pwdata[mpe_pkg::CAP_W-1:0];
                mpe_pkg::REG_SCREEN_COLS:  r_cfg.screen_columns <= pwdata[mpe_pkg::SCR_W-1:0];
                mpe_pkg::REG_SCREEN_ROWS:  r_cfg.screen_rows <= pwdata[mpe_pkg::SCR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // read back, zero-extended to the bus
    always_comb begin
        unique case (reg_idx)
            mpe_pkg::REG_X_SPAN:       prdata = mpe_pkg::DATA_W'(r_cfg.x_span);
            mpe_pkg::REG_X_OFFSET:     prdata = mpe_pkg::DATA_W'(r_cfg.x_offset);
            mpe_pkg::REG_Y_SPAN:       prdata = mpe_pkg::DATA_W'(r_cfg.y_span);
            mpe_pkg::REG_Y_OFFSET:     prdata = mpe_pkg::DATA_W'(r_cfg.y_offset);
            mpe_pkg::REG_ESCAPE_LIMIT: prdata = mpe_pkg::DATA_W'(r_cfg.escape_limit);
            mpe_pkg::REG_ITER_CAP:     prdata = mpe_pkg::DATA_W'(r_cfg.iteration_cap);
            mpe_pkg::REG_SCREEN_COLS:  prdata = mpe_pkg::DATA_W'(r_cfg.screen_columns);
            mpe_pkg::REG_SCREEN_ROWS:  prdata = mpe_pkg::DATA_W'(r_cfg.screen_rows);
            default:                   prdata = '0;
        endcase
    end

    mpe_seq u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_start       (start),
        .i_column      (i_column),
        .i_row         (i_row),
        .o_busy        (busy),
        .o_strobe      (o_strobe),
        .o_shade_index (o_shade_index),
        .o_glyph       (o_glyph)
    );

endmodule

>>> rtl/core/mpe_checker.sv
module mpe_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           start,
    input logic                           busy,
    input logic                           o_strobe,
    input logic [mpe_pkg::CAP_W-1:0]      o_shade_index,
    input logic [mpe_pkg::GLYPH_W-1:0]    o_glyph
);

    // a taken pixel occupies the block on the next cycle
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("pixel taken but block not busy");

    // results come only at the end of a busy stretch
    a_strobe_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (!busy && $past(busy)))
        else $error("strobe without a pixel in flight");

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("two results in consecutive cycles");

    a_shade_glyph: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_shade_index < mpe_pkg::CAP_W'(mpe_pkg::SHADE_COUNT)
                      && o_glyph == mpe_pkg::shade_glyph(o_shade_index)))
        else $error("shade index or glyph out of table");

endmodule

bind mandelbrot_pixel_escape mpe_checker u_mpe_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .o_strobe      (o_strobe),
    .o_shade_index (o_shade_index),
    .o_glyph       (o_glyph)
);
